// ----- hw/rtl/vector_reflect_about_normal_assert.svh -----
// ----------------------------------------------------------------------------
// vector_reflect_about_normal_assert.svh
// Assertion macros used by the reflection unit checker.
// ----------------------------------------------------------------------------
`ifndef VECTOR_REFLECT_ABOUT_NORMAL_ASSERT_SVH
`define VECTOR_REFLECT_ABOUT_NORMAL_ASSERT_SVH

// same-cycle implication, off during reset
`define VRN_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("vrn assertion failed");

// next-cycle implication, off during reset
`define VRN_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("vrn assertion failed");

// next-cycle implication, always checked
`define VRN_ASSERT_NEXT_ALL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("vrn assertion failed");

`endif

// ----- hw/rtl/vrn_pkg.sv -----
// ----------------------------------------------------------------------------
// vrn_pkg
// Transfer types and fixed constants of the vector reflection unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package vrn_pkg;

  localparam int COMP_W      = 32;
  localparam int ISQRT_STEPS = 32;
  localparam int SQ_W        = 64;
  localparam int SQ_REM_W    = 34;
  localparam int M_W         = 34;

  typedef struct packed {
    logic signed [COMP_W-1:0] incident_x;
    logic signed [COMP_W-1:0] incident_y;
    logic signed [COMP_W-1:0] incident_z;
    logic signed [COMP_W-1:0] normal_x;
    logic signed [COMP_W-1:0] normal_y;
    logic signed [COMP_W-1:0] normal_z;
  } vrn_in_t;

  typedef struct packed {
    logic signed [COMP_W-1:0] reflected_x;
    logic signed [COMP_W-1:0] reflected_y;
    logic signed [COMP_W-1:0] reflected_z;
    logic                     zero_normal;
    logic                     saturated;
  } vrn_out_t;

endpackage

// ----- hw/rtl/vector_reflect_about_normal.sv -----
// ----------------------------------------------------------------------------
// vector_reflect_about_normal
// Reflects an incident vector about a normalized surface normal, Q fixed point.
// Throughput: one item per cycle while out_stall does not hold the output; a
// 32-step square root pipeline and a FRAC_BITS + 1 step divide pipeline, one bit per stage.
// Reset: synchronous active-low rst_n clears all stage valids; no clearing pass.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module vector_reflect_about_normal #(
  parameter int FRAC_BITS = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  vrn_pkg::vrn_in_t in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output vrn_pkg::vrn_out_t out_data
);
  import vrn_pkg::*;

  localparam int DV_N = FRAC_BITS + 1;
  localparam int DW   = COMP_W + FRAC_BITS;
  localparam int QW   = FRAC_BITS + 1;
  localparam int NHW  = FRAC_BITS + 2;
  localparam int PW   = COMP_W + NHW;
  localparam int DOTW = PW + 2;
  localparam int MPW  = M_W + NHW;
  localparam int TW   = MPW + 1;
  localparam int TQW  = TW - FRAC_BITS;
  localparam int RW   = TQW + 1;
  localparam logic signed [DOTW-1:0] DOT_BIAS = DOTW'((64'd1 << FRAC_BITS) - 64'd1);
  localparam logic signed [TW-1:0]   T_BIAS   = TW'((64'd1 << FRAC_BITS) - 64'd1);
  localparam logic signed [RW-1:0]   R_MAX    = RW'(64'h7FFF_FFFF);
  localparam logic signed [RW-1:0]   R_MIN    = -RW'(64'h8000_0000);

  logic en;
  logic out_valid_r;
  vrn_out_t out_data_r;

  assign en        = !(out_valid_r && out_stall);
  assign in_stall  = !en;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // input stage
  logic a_v_r;
  logic signed [COMP_W-1:0] a_d_r [3];
  logic signed [COMP_W-1:0] a_n_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
    end else if (en) begin
      a_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_d_r[0] <= in_data.incident_x;
      a_d_r[1] <= in_data.incident_y;
      a_d_r[2] <= in_data.incident_z;
      a_n_r[0] <= in_data.normal_x;
      a_n_r[1] <= in_data.normal_y;
      a_n_r[2] <= in_data.normal_z;
    end
  end

  // squares
  logic b_v_r;
  logic signed [COMP_W-1:0] b_d_r [3];
  logic signed [COMP_W-1:0] b_n_r [3];
  logic signed [SQ_W-1:0]   b_sq_r [3];
  logic signed [SQ_W-1:0]   b_sq_nxt [3];

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      b_sq_nxt[l] = a_n_r[l] * a_n_r[l];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_v_r <= 1'b0;
    end else if (en) begin
      b_v_r <= a_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b_d_r  <= a_d_r;
      b_n_r  <= a_n_r;
      b_sq_r <= b_sq_nxt;
    end
  end

  // square root: index 0 holds the sum, each later index one result bit
  logic                   sq_v_r    [0:ISQRT_STEPS];
  logic                   sq_z_r    [0:ISQRT_STEPS];
  logic [SQ_W-1:0]        sq_x_r    [0:ISQRT_STEPS];
  logic [SQ_REM_W-1:0]    sq_rem_r  [0:ISQRT_STEPS];
  logic [COMP_W-1:0]      sq_root_r [0:ISQRT_STEPS];
  logic signed [COMP_W-1:0] sq_d_r  [0:ISQRT_STEPS][3];
  logic signed [COMP_W-1:0] sq_n_r  [0:ISQRT_STEPS][3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_v_r[0] <= 1'b0;
    end else if (en) begin
      sq_v_r[0] <= b_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq_z_r[0]    <= (b_n_r[0] == '0) && (b_n_r[1] == '0) && (b_n_r[2] == '0);
      sq_x_r[0]    <= SQ_W'(b_sq_r[0]) + SQ_W'(b_sq_r[1]) + SQ_W'(b_sq_r[2]);
      sq_rem_r[0]  <= '0;
      sq_root_r[0] <= '0;
      sq_d_r[0]    <= b_d_r;
      sq_n_r[0]    <= b_n_r;
    end
  end

  for (genvar j = 1; j <= ISQRT_STEPS; j++) begin : g_sqrt
    logic [SQ_REM_W+1:0] rs_w;
    logic [SQ_REM_W+1:0] tr_w;
    logic [SQ_REM_W+1:0] df_w;
    logic                ge_w;

    always_comb begin
      rs_w = {sq_rem_r[j-1], sq_x_r[j-1][SQ_W-1 -: 2]};
      tr_w = {2'b00, sq_root_r[j-1], 2'b01};
      ge_w = rs_w >= tr_w;
      df_w = rs_w - tr_w;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sq_v_r[j] <= 1'b0;
      end else if (en) begin
        sq_v_r[j] <= sq_v_r[j-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sq_z_r[j]    <= sq_z_r[j-1];
        sq_x_r[j]    <= {sq_x_r[j-1][SQ_W-3:0], 2'b00};
        sq_rem_r[j]  <= ge_w ? df_w[SQ_REM_W-1:0] : rs_w[SQ_REM_W-1:0];
        sq_root_r[j] <= {sq_root_r[j-1][COMP_W-2:0], ge_w};
        sq_d_r[j]    <= sq_d_r[j-1];
        sq_n_r[j]    <= sq_n_r[j-1];
      end
    end
  end

  // divide |n| << FRAC_BITS by the length, one quotient bit per stage
  logic                     dv_v_r   [0:DV_N];
  logic                     dv_z_r   [0:DV_N];
  logic [COMP_W-1:0]        dv_len_r [0:DV_N];
  logic [DW-1:0]            dv_rm_r  [0:DV_N][3];
  logic [QW-1:0]            dv_q_r   [0:DV_N][3];
  logic                     dv_s_r   [0:DV_N][3];
  logic signed [COMP_W-1:0] dv_d_r   [0:DV_N][3];
  logic [COMP_W-1:0]        dv_mag_w [3];

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      dv_mag_w[l] = sq_n_r[ISQRT_STEPS][l][COMP_W-1] ?
                    (~sq_n_r[ISQRT_STEPS][l]) + 1'b1 : sq_n_r[ISQRT_STEPS][l];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_v_r[0] <= 1'b0;
    end else if (en) begin
      dv_v_r[0] <= sq_v_r[ISQRT_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dv_z_r[0]   <= sq_z_r[ISQRT_STEPS];
      dv_len_r[0] <= sq_root_r[ISQRT_STEPS];
      dv_d_r[0]   <= sq_d_r[ISQRT_STEPS];
      for (int l = 0; l < 3; l++) begin
        dv_rm_r[0][l] <= {dv_mag_w[l], {FRAC_BITS{1'b0}}};
        dv_q_r[0][l]  <= '0;
        dv_s_r[0][l]  <= sq_n_r[ISQRT_STEPS][l][COMP_W-1];
      end
    end
  end

  for (genvar k = 1; k <= DV_N; k++) begin : g_div
    localparam int SH = DV_N - k;
    logic [DW-1:0] dsh_w;
    logic          ge_w [3];

    always_comb begin
      dsh_w = DW'(dv_len_r[k-1]) << SH;
      for (int l = 0; l < 3; l++) begin
        ge_w[l] = dv_rm_r[k-1][l] >= dsh_w;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_v_r[k] <= 1'b0;
      end else if (en) begin
        dv_v_r[k] <= dv_v_r[k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dv_z_r[k]   <= dv_z_r[k-1];
        dv_len_r[k] <= dv_len_r[k-1];
        dv_d_r[k]   <= dv_d_r[k-1];
        for (int l = 0; l < 3; l++) begin
          dv_rm_r[k][l] <= ge_w[l] ? dv_rm_r[k-1][l] - dsh_w : dv_rm_r[k-1][l];
          dv_q_r[k][l]  <= {dv_q_r[k-1][l][QW-2:0], ge_w[l]};
          dv_s_r[k][l]  <= dv_s_r[k-1][l];
        end
      end
    end
  end

  // signed unit normal
  logic e_v_r;
  logic e_z_r;
  logic signed [COMP_W-1:0] e_d_r  [3];
  logic signed [NHW-1:0]    e_nh_r [3];
  logic signed [NHW-1:0]    e_nh_nxt [3];

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      e_nh_nxt[l] = dv_s_r[DV_N][l] ? -$signed({1'b0, dv_q_r[DV_N][l]}) :
                                        $signed({1'b0, dv_q_r[DV_N][l]});
    end
  end

  // d . n_hat products
  logic f_v_r;
  logic f_z_r;
  logic signed [COMP_W-1:0] f_d_r    [3];
  logic signed [NHW-1:0]    f_nh_r   [3];
  logic signed [PW-1:0]     f_prod_r [3];
  logic signed [PW-1:0]     f_prod_nxt [3];

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      f_prod_nxt[l] = e_d_r[l] * e_nh_r[l];
    end
  end

  // dot sum
  logic g_v_r;
  logic g_z_r;
  logic signed [COMP_W-1:0] g_d_r  [3];
  logic signed [NHW-1:0]    g_nh_r [3];
  logic signed [DOTW-1:0]   g_dot_r;

  // m = -(dot / one), toward zero
  logic h_v_r;
  logic h_z_r;
  logic signed [COMP_W-1:0] h_d_r  [3];
  logic signed [NHW-1:0]    h_nh_r [3];
  logic signed [M_W-1:0]    h_m_r;
  logic signed [DOTW-1:0]   h_dotb_w;
  logic signed [DOTW-1:0]   h_dq_w;

  always_comb begin
    h_dotb_w = g_dot_r + (g_dot_r[DOTW-1] ? DOT_BIAS : '0);
    h_dq_w   = h_dotb_w >>> FRAC_BITS;
  end

  // m * n_hat
  logic i_v_r;
  logic i_z_r;
  logic signed [COMP_W-1:0] i_d_r  [3];
  logic signed [MPW-1:0]    i_mp_r [3];
  logic signed [MPW-1:0]    i_mp_nxt [3];

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      i_mp_nxt[l] = h_m_r * h_nh_r[l];
    end
  end

  // t = 2 * m * n_hat / one, toward zero
  logic j_v_r;
  logic j_z_r;
  logic signed [COMP_W-1:0] j_d_r [3];
  logic signed [TQW-1:0]    j_t_r [3];
  logic signed [TQW-1:0]    j_t_nxt [3];
  logic signed [TW-1:0]     j_x2_w [3];
  logic signed [TW-1:0]     j_xb_w [3];

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      j_x2_w[l]  = $signed({i_mp_r[l], 1'b0});
      j_xb_w[l]  = j_x2_w[l] + (j_x2_w[l][TW-1] ? T_BIAS : '0);
      j_t_nxt[l] = TQW'(j_xb_w[l] >>> FRAC_BITS);
    end
  end

  // sum and clamp
  logic signed [RW-1:0]     k_r_w   [3];
  logic signed [COMP_W-1:0] k_c_w   [3];
  logic                     k_sat_w [3];
  vrn_out_t                 out_data_nxt;

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      k_r_w[l] = RW'(j_d_r[l]) + RW'(j_t_r[l]);
      if (j_z_r) begin
        k_c_w[l]   = j_d_r[l];
        k_sat_w[l] = 1'b0;
      end else if (k_r_w[l] > R_MAX) begin
        k_c_w[l]   = COMP_W'(R_MAX);
        k_sat_w[l] = 1'b1;
      end else if (k_r_w[l] < R_MIN) begin
        k_c_w[l]   = COMP_W'(R_MIN);
        k_sat_w[l] = 1'b1;
      end else begin
        k_c_w[l]   = COMP_W'(k_r_w[l]);
        k_sat_w[l] = 1'b0;
      end
    end
    out_data_nxt.reflected_x = k_c_w[0];
    out_data_nxt.reflected_y = k_c_w[1];
    out_data_nxt.reflected_z = k_c_w[2];
    out_data_nxt.zero_normal = j_z_r;
    out_data_nxt.saturated   = k_sat_w[0] | k_sat_w[1] | k_sat_w[2];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e_v_r       <= 1'b0;
      f_v_r       <= 1'b0;
      g_v_r       <= 1'b0;
      h_v_r       <= 1'b0;
      i_v_r       <= 1'b0;
      j_v_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      e_v_r       <= dv_v_r[DV_N];
      f_v_r       <= e_v_r;
      g_v_r       <= f_v_r;
      h_v_r       <= g_v_r;
      i_v_r       <= h_v_r;
      j_v_r       <= i_v_r;
      out_valid_r <= j_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      e_z_r    <= dv_z_r[DV_N];
      e_d_r    <= dv_d_r[DV_N];
      e_nh_r   <= e_nh_nxt;
      f_z_r    <= e_z_r;
      f_d_r    <= e_d_r;
      f_nh_r   <= e_nh_r;
      f_prod_r <= f_prod_nxt;
      g_z_r    <= f_z_r;
      g_d_r    <= f_d_r;
      g_nh_r   <= f_nh_r;
      g_dot_r  <= DOTW'(f_prod_r[0]) + DOTW'(f_prod_r[1]) + DOTW'(f_prod_r[2]);
      h_z_r    <= g_z_r;
      h_d_r    <= g_d_r;
      h_nh_r   <= g_nh_r;
      h_m_r    <= -M_W'(h_dq_w);
      i_z_r    <= h_z_r;
      i_d_r    <= h_d_r;
      i_mp_r   <= i_mp_nxt;
      j_z_r    <= i_z_r;
      j_d_r    <= i_d_r;
      j_t_r    <= j_t_nxt;
      out_data_r <= out_data_nxt;
    end
  end

endmodule

// ----- hw/rtl/vector_reflect_about_normal_chk.sv -----
// ----------------------------------------------------------------------------
// vector_reflect_about_normal_chk
// Port-level checks on the reflection unit, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "vector_reflect_about_normal_assert.svh"

module vector_reflect_about_normal_chk (
  input logic              clk,
  input logic              rst_n,
  input logic              in_stall,
  input logic              out_valid,
  input logic              out_stall,
  input vrn_pkg::vrn_out_t out_data
);
  import vrn_pkg::*;

  `VRN_ASSERT_NEXT_ALL(a_rst_idle, !rst_n, !out_valid)
  `VRN_ASSERT_IMP(a_zero_no_sat, out_valid, !(out_data.zero_normal && out_data.saturated))
  `VRN_ASSERT_IMP(a_backpressure, out_valid && out_stall, in_stall)
  `VRN_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data))

endmodule

bind vector_reflect_about_normal vector_reflect_about_normal_chk u_chk (.*);
